>>> hw/rtl/dlpg_pkg.sv
`timescale 1ns / 1ps

package dlpg_pkg;

    // Default geometry of the coordinate datapath
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    // Width of the step size register
    localparam int STEP_BITS = 4;

    // Operation codes carried on the input channel
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Status of the divider as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> hw/rtl/dlpg_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in COORD_BITS + FRAC_BITS bits, so the upper part of the
// dividend is already below the divisor and seeds the remainder directly.
module dlpg_divider #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlpg_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [2*COORD_BITS+FRAC_BITS-1:0]    dividend,
    input  logic [COORD_BITS-1:0]                divisor,
    output dlpg_pkg::div_status_t                status,
    output logic [COORD_BITS+FRAC_BITS-1:0]      quotient
);

    localparam int QB = COORD_BITS + FRAC_BITS;
    localparam int CW = $clog2(QB + 1);

    logic [COORD_BITS-1:0] rem_reg;
    logic [QB-1:0]         quo_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;

    // Trial subtraction for the current quotient bit
    always_comb begin
        trial = {rem_reg, quo_reg[QB-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
    end

    // Control: count the quotient bits, flag the end for one cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QB);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend through, collecting quotient bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[2*COORD_BITS+FRAC_BITS-1:QB];
            quo_reg <= dividend[QB-1:0];
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            quo_reg <= {quo_reg[QB-2:0], ge};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

>>> hw/rtl/dda_line_point_generator.sv
`timescale 1ns / 1ps

// DDA line point generator. A start item (op 0) loads two endpoints and
// produces no output; equal endpoints leave no line active. Each tick item
// (op 1) on an active line produces one point: the major axis coordinate
// advances by step_size per point (a step size of zero acts as one), the
// minor coordinate is interpolated in signed fixed point with FRAC_BITS
// fraction bits, its offset from the start truncated toward zero, and the
// final point carries m_last. A tick with no active line is consumed with
// no output. A tick on an active line keeps the input side busy through the
// multiply, the divider load, the restoring divider and the output load, so
// the next item is taken only once the point is in the output register. The
// result sits in an output register, so a waiting point does not stop the
// next tick from being accepted and worked on.
module dda_line_point_generator #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlpg_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [dlpg_pkg::STEP_BITS-1:0]      cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic signed [COORD_BITS-1:0]        s_start_x,
    input  logic signed [COORD_BITS-1:0]        s_start_y,
    input  logic signed [COORD_BITS-1:0]        s_end_x,
    input  logic signed [COORD_BITS-1:0]        s_end_y,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [COORD_BITS-1:0]               m_point_index,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] m_point_x,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] m_point_y,
    output logic                                m_last
);

    localparam int W  = COORD_BITS + FRAC_BITS;
    localparam int DW = 2 * COORD_BITS + FRAC_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;

    logic [dlpg_pkg::STEP_BITS-1:0] step_reg;

    // Line state, kept as magnitudes and signs
    logic                           line_active_reg;
    logic [COORD_BITS-1:0]          off_mag_reg;
    logic signed [COORD_BITS-1:0]   origin_x_reg;
    logic signed [COORD_BITS-1:0]   origin_y_reg;
    logic [COORD_BITS-1:0]          maj_mag_reg;
    logic                           maj_neg_reg;
    logic [COORD_BITS-1:0]          min_mag_reg;
    logic                           min_neg_reg;
    logic                           x_is_minor_reg;

    logic [2*COORD_BITS-1:0]        prod_reg;

    logic                           m_valid_reg;
    logic [COORD_BITS-1:0]          point_index_reg;
    logic [W-1:0]                   point_x_reg;
    logic [W-1:0]                   point_y_reg;
    logic                           last_reg;

    logic                           s_xfer;
    logic                           out_free;

    logic signed [COORD_BITS:0]     dx;
    logic signed [COORD_BITS:0]     dy;
    logic signed [COORD_BITS:0]     dx_neg;
    logic signed [COORD_BITS:0]     dy_neg;
    logic [COORD_BITS-1:0]          dx_mag;
    logic [COORD_BITS-1:0]          dy_mag;
    logic                           x_major;

    logic [COORD_BITS:0]            stride;
    logic [COORD_BITS:0]            next_mag;
    logic                           is_last;

    logic [DW-1:0]                  dividend;
    logic [W-1:0]                   quotient;
    dlpg_pkg::div_status_t          div_status;

    logic signed [COORD_BITS:0]     off_signed;
    logic signed [COORD_BITS:0]     origin_maj;
    logic signed [COORD_BITS:0]     maj_sum;
    logic [W-1:0]                   frac_w;
    logic [W-1:0]                   origin_min_w;
    logic [W-1:0]                   maj_w;
    logic [W-1:0]                   min_w;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Endpoint deltas and major axis choice for a start item
    always_comb begin
        dx      = (COORD_BITS + 1)'(s_end_x) - (COORD_BITS + 1)'(s_start_x);
        dy      = (COORD_BITS + 1)'(s_end_y) - (COORD_BITS + 1)'(s_start_y);
        dx_neg  = -dx;
        dy_neg  = -dy;
        dx_mag  = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        dy_mag  = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        x_major = (dx_mag > dy_mag);
    end

    // Offset advance and end of line test
    always_comb begin
        stride   = (step_reg == '0) ? (COORD_BITS + 1)'(1)
                                    : (COORD_BITS + 1)'(step_reg);
        next_mag = (COORD_BITS + 1)'(off_mag_reg) + stride;
        is_last  = (next_mag > (COORD_BITS + 1)'(maj_mag_reg));
    end

    // Point coordinates from the line state and the quotient
    always_comb begin
        off_signed   = maj_neg_reg ? -((COORD_BITS + 1)'(off_mag_reg))
                                   : (COORD_BITS + 1)'(off_mag_reg);
        origin_maj   = x_is_minor_reg ? (COORD_BITS + 1)'(origin_y_reg)
                                      : (COORD_BITS + 1)'(origin_x_reg);
        maj_sum      = origin_maj + off_signed;
        maj_w        = W'(maj_sum) << FRAC_BITS;
        origin_min_w = x_is_minor_reg ? W'(origin_x_reg) : W'(origin_y_reg);
        frac_w       = min_neg_reg ? (~quotient + W'(1)) : quotient;
        min_w        = (origin_min_w << FRAC_BITS) + frac_w;
    end

    assign dividend = DW'(prod_reg) << FRAC_BITS;

    dlpg_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_LOAD),
        .dividend (dividend),
        .divisor  (maj_mag_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_op == dlpg_pkg::OP_TICK && line_active_reg) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Step size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= dlpg_pkg::STEP_BITS'(1);
        end else if (cfg_we) begin
            step_reg <= cfg_wdata;
        end
    end

    // Line state: load on start, advance on each emitted point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            off_mag_reg     <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            maj_mag_reg     <= '0;
            maj_neg_reg     <= 1'b0;
            min_mag_reg     <= '0;
            min_neg_reg     <= 1'b0;
            x_is_minor_reg  <= 1'b0;
        end else if (s_xfer && s_op == dlpg_pkg::OP_START) begin
            line_active_reg <= (dx != '0) || (dy != '0);
            off_mag_reg     <= '0;
            origin_x_reg    <= s_start_x;
            origin_y_reg    <= s_start_y;
            x_is_minor_reg  <= !x_major;
            if (x_major) begin
                maj_mag_reg <= dx_mag;
                maj_neg_reg <= dx[COORD_BITS];
                min_mag_reg <= dy_mag;
                min_neg_reg <= dy[COORD_BITS];
            end else begin
                maj_mag_reg <= dy_mag;
                maj_neg_reg <= dy[COORD_BITS];
                min_mag_reg <= dx_mag;
                min_neg_reg <= dx[COORD_BITS];
            end
        end else if (state_reg == ST_OUT && out_free) begin
            if (is_last) begin
                line_active_reg <= 1'b0;
                off_mag_reg     <= '0;
            end else begin
                off_mag_reg     <= next_mag[COORD_BITS-1:0];
            end
        end
    end

    // Product of offset and minor delta magnitudes
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            prod_reg <= (2 * COORD_BITS)'(off_mag_reg) * (2 * COORD_BITS)'(min_mag_reg);
        end
    end

    // Output register: hold until the transfer, then drop or reload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            point_index_reg <= off_mag_reg;
            point_x_reg     <= x_is_minor_reg ? min_w : maj_w;
            point_y_reg     <= x_is_minor_reg ? maj_w : min_w;
            last_reg        <= is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_point_index = point_index_reg;
    assign m_point_x     = point_x_reg;
    assign m_point_y     = point_y_reg;
    assign m_last        = last_reg;

endmodule

>>> hw/rtl/dlpg_checker.sv
`timescale 1ns / 1ps

module dlpg_checker #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlpg_pkg::FRAC_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [COORD_BITS-1:0]               m_point_index,
    input logic [COORD_BITS+FRAC_BITS-1:0]     m_point_x,
    input logic [COORD_BITS+FRAC_BITS-1:0]     m_point_y,
    input logic                                m_last
);

    // A stalled point holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_index) && $stable(m_point_x)
            && $stable(m_point_y) && $stable(m_last))
        else $error("stalled point changed");

    // An accepted item does not produce a point right after its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid) ##1 !$rose(m_valid))
        else $error("point appeared too soon after an accepted item");

    // A new point only appears after a busy cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("point appeared without a busy cycle");

    // While busy and the output is stalled, the input side stays closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && m_valid && !m_ready |=> !s_ready)
        else $error("input reopened while a point was stalled");

endmodule

bind dda_line_point_generator dlpg_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_dlpg_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CB = dlpg_pkg::COORD_BITS_DEF;
    localparam int FB = dlpg_pkg::FRAC_BITS_DEF;
    localparam int SB = dlpg_pkg::STEP_BITS;
    localparam int ITEM_TARGET = 1700;
    localparam int PHASES = 9;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        bit [CB-1:0]    index;
        bit [CB+FB-1:0] x;
        bit [CB+FB-1:0] y;
        bit             last;
    } point_t;

    // Line state mirror plus the queue of points still owed by the block
    class line_point_predictor;
        bit          active;
        int          offs;
        int          org_x;
        int          org_y;
        int          minor_d;
        int          major_d;
        bit          x_minor;
        bit [SB-1:0] step;
        point_t      pending[$];
        int          errors;
        int          checked;

        function new();
            active  = 0;
            offs    = 0;
            org_x   = 0;
            org_y   = 0;
            minor_d = 0;
            major_d = 0;
            x_minor = 0;
            step    = 1;
            errors  = 0;
            checked = 0;
        endfunction

        function int mag(int v);
            return v < 0 ? -v : v;
        endfunction

        function void set_step(bit [SB-1:0] v);
            step = v;
        endfunction

        // Note an accepted input transfer; return 1 unless it was an ignored tick
        function bit accept_item(bit op, logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                                 logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
            int     dx;
            int     dy;
            int     stride;
            int     inc;
            int     nxt;
            bit     is_last;
            longint one;
            longint frac;
            longint px;
            longint py;
            point_t pt;
            one = longint'(1) << FB;
            if (op == dlpg_pkg::OP_START) begin
                dx = int'(ex) - int'(sx);
                dy = int'(ey) - int'(sy);
                org_x = int'(sx);
                org_y = int'(sy);
                offs = 0;
                if (mag(dx) > mag(dy)) begin
                    minor_d = dy;
                    major_d = dx;
                    x_minor = 0;
                end else begin
                    minor_d = dx;
                    major_d = dy;
                    x_minor = 1;
                end
                active = (dx != 0) || (dy != 0);
                return 1;
            end
            if (!active)
                return 0;
            stride = (step == 0) ? 1 : int'(step);
            inc = (major_d < 0) ? -stride : stride;
            nxt = offs + inc;
            is_last = mag(nxt) > mag(major_d);
            frac = (longint'(offs) * longint'(minor_d) * one) / longint'(major_d);
            if (x_minor) begin
                px = longint'(org_x) * one + frac;
                py = (longint'(org_y) + longint'(offs)) * one;
            end else begin
                px = (longint'(org_x) + longint'(offs)) * one;
                py = longint'(org_y) * one + frac;
            end
            pt.index = CB'(mag(offs));
            pt.x = px[CB+FB-1:0];
            pt.y = py[CB+FB-1:0];
            pt.last = is_last;
            pending.push_back(pt);
            if (is_last) begin
                active = 0;
                offs = 0;
            end else begin
                offs = nxt;
            end
            return 1;
        endfunction

        // Compare one output transfer with the oldest owed point
        function void check_point(point_t got);
            point_t exp_pt;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: point with none owed: idx %0d x %h y %h last %0d",
                             $realtime, got.index, got.x, got.y, got.last);
                return;
            end
            exp_pt = pending.pop_front();
            if (got != exp_pt) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("%0t: mismatch", $realtime);
                    $display("  expected idx %0d x %h y %h last %0d",
                             exp_pt.index, exp_pt.x, exp_pt.y, exp_pt.last);
                    $display("  actual   idx %0d x %h y %h last %0d",
                             got.index, got.x, got.y, got.last);
                end
            end
        endfunction
    endclass

    logic                    aclk = 0;
    logic                    aresetn = 0;
    logic                    cfg_we = 0;
    logic [SB-1:0]           cfg_wdata = '0;
    logic                    s_valid = 0;
    logic                    s_ready;
    logic                    s_op = 0;
    logic signed [CB-1:0]    s_start_x = '0;
    logic signed [CB-1:0]    s_start_y = '0;
    logic signed [CB-1:0]    s_end_x = '0;
    logic signed [CB-1:0]    s_end_y = '0;
    logic                    m_valid;
    logic                    m_ready = 0;
    logic [CB-1:0]           m_point_index;
    logic signed [CB+FB-1:0] m_point_x;
    logic signed [CB+FB-1:0] m_point_y;
    logic                    m_last;

    line_point_predictor sb;
    bit idle_en = 1;
    bit hold_request = 0;
    int hold_left = 0;
    int quiet = 0;
    int item_count = 0;
    int line_count = 0;

    dda_line_point_generator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_index (m_point_index),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_last        (m_last)
    );

    always #4 aclk = ~aclk;

    // Receiver: random back-pressure, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_en || ($urandom_range(99) >= 36);
        end
    end

    // Check every output transfer
    always @(posedge aclk) begin
        point_t got;
        if (aresetn && m_valid && m_ready) begin
            got.index = m_point_index;
            got.x = m_point_x;
            got.y = m_point_y;
            got.last = m_last;
            sb.check_point(got);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d points owed",
                         $realtime, quiet, sb.pending.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(bit op, logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                             logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
        bit useful;
        while (idle_en && ($urandom_range(99) < 36)) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_op      <= op;
        s_start_x <= sx;
        s_start_y <= sy;
        s_end_x   <= ex;
        s_end_y   <= ey;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        useful = sb.accept_item(op, sx, sy, ex, ey);
        if (useful)
            item_count++;
    endtask

    // Tick with random payload in the unused fields
    task automatic tick();
        send_item(dlpg_pkg::OP_TICK, CB'($urandom), CB'($urandom), CB'($urandom),
                  CB'($urandom));
    endtask

    task automatic start_line(logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                              logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
        send_item(dlpg_pkg::OP_START, sx, sy, ex, ey);
        line_count++;
    endtask

    task automatic ticks(int n);
        repeat (n) tick();
    endtask

    // Drop valid, wait for every owed point, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step(bit [SB-1:0] v);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sb.set_step(v);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Endpoint a small distance away, reflected to stay in range
    function automatic logic signed [CB-1:0] fit_end(logic signed [CB-1:0] s, int d);
        int e;
        e = int'(s) + d;
        if (e > (1 << (CB - 1)) - 1 || e < -(1 << (CB - 1)))
            e = int'(s) - d;
        return e[CB-1:0];
    endfunction

    // One random line: mostly short and run to the end, some cut short or degenerate
    task automatic run_line(bit big);
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        int cap;
        int n;
        int r;
        sx = CB'($urandom);
        sy = CB'($urandom);
        if (big) begin
            ex = CB'($urandom);
            ey = CB'($urandom);
        end else begin
            ex = fit_end(sx, int'($urandom_range(40)) - 20);
            ey = fit_end(sy, int'($urandom_range(40)) - 20);
        end
        if ($urandom_range(99) < 5) begin
            ex = sx;
            ey = sy;
        end
        start_line(sx, sy, ex, ey);
        r = int'($urandom_range(99));
        if (r < 15)
            cap = int'($urandom_range(5));
        else if (big && sb.step < 12)
            cap = 30;
        else
            cap = 1 << 14;
        n = 0;
        while (sb.active && n < cap) begin
            tick();
            n++;
        end
        // Stray ticks after the line has ended
        if ($urandom_range(99) < 20)
            ticks(int'($urandom_range(1, 2)));
    endtask

    initial begin
        int phase;
        int target;
        bit [SB-1:0] nstep;
        bit drained_mid;

        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: tick with no line
        tick();
        // Diagonal tie over the full range, y is major
        start_line(-2048, -2048, 2047, 2047);
        ticks(3);
        // Start during a line, opposite diagonal
        start_line(2047, -2048, -2048, 2047);
        ticks(2);
        // Equal endpoints leave no line
        start_line(0, 0, 0, 0);
        tick();
        // Short x-major line in the negative direction, run past its end
        start_line(5, 3, -1, 4);
        ticks(8);
        // Horizontal line at the top edge
        start_line(-2048, 2047, 2047, 2047);
        ticks(2);

        // Random phases; each one after the first writes a new step setting
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: nstep = 1;
                1: nstep = 0;
                2: nstep = 15;
                3: nstep = 1;
                default: nstep = SB'($urandom_range(15));
            endcase
            if (phase != 0)
                write_step(nstep);
            idle_en = (phase != 3);
            if (phase == 4)
                hold_request = 1;
            // Full-length line at the largest step
            if (phase == 2) begin
                start_line(-2048, 0, 2047, 5);
                while (sb.active)
                    tick();
            end
            drained_mid = 0;
            target = ((phase + 1) * ITEM_TARGET) / PHASES;
            while (item_count < target) begin
                if (phase == 5 && !drained_mid && item_count > target - 80) begin
                    drain();
                    drained_mid = 1;
                end
                run_line($urandom_range(99) < 5);
            end
        end

        drain();
        idle_en = 1;
        $display("covered %0d items over %0d lines and %0d step settings, %0d points checked",
                 item_count, line_count, PHASES, sb.checked);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
